FILE: rtl/hfl_pkg.sv
`default_nettype none

package hfl_pkg;

    localparam int PROB_FRAC_BITS = 16;
    localparam int PROB_W         = PROB_FRAC_BITS + 1;
    localparam int LOG_W          = 48;
    localparam int LOG_FRAC       = 16;
    localparam int LN_W           = 32;
    localparam int MANT_W         = 31;

    localparam logic [PROB_W-1:0] ONE_PROB  = PROB_W'(1) << PROB_FRAC_BITS;
    localparam logic [PROB_W-1:0] T_MAX     = '1;
    localparam logic [31:0]       LN2_Q32   = 32'd2977044472;
    localparam logic signed [LOG_W-1:0] LOG_MIN = {1'b1, {(LOG_W-1){1'b0}}};
    localparam logic signed [LOG_W-1:0] LOG_MAX = {1'b0, {(LOG_W-1){1'b1}}};

    typedef enum logic [1:0] {
        FUNC_INIT  = 2'd0,
        FUNC_TRANS = 2'd1,
        FUNC_EMIS  = 2'd2,
        FUNC_OBS   = 2'd3
    } func_t;

    typedef struct packed {
        func_t             func;
        logic [3:0]        row_state;
        logic [7:0]        col_index;
        logic [PROB_W-1:0] prob_value;
        logic [7:0]        symbol;
        logic              last;
    } in_t;

    typedef struct packed {
        logic signed [LOG_W-1:0] loglik;
        logic                    zero_prob;
    } out_t;

endpackage

`default_nettype wire

FILE: rtl/hfl_ram.sv
`default_nettype none

module hfl_ram #(
    parameter int WIDTH = 17,
    parameter int DEPTH = 16
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

FILE: rtl/hfl_log.sv
`default_nettype none

module hfl_log
    import hfl_pkg::*;
#(
    parameter int SUM_W = 38
) (
    input  wire logic                    aclk,
    input  wire logic                    aresetn,
    input  wire logic                    start,
    input  wire logic [SUM_W-1:0]        sum_in,
    output logic                         done,
    output logic signed [LN_W-1:0]       ln
);

    localparam int KW  = $clog2(SUM_W);
    localparam int DW  = KW + 2;
    localparam int L2W = DW + LOG_FRAC;
    localparam int PW  = L2W + 33;
    localparam int BW  = $clog2(LOG_FRAC + 1);
    localparam logic signed [PW-1:0] RND = PW'(64'sd2147483648);
    localparam logic signed [32:0]   LN2_S = {1'b0, LN2_Q32};

    typedef enum logic [2:0] {
        L_IDLE, L_NORM, L_SQ, L_CHK, L_MUL, L_RND
    } lstate_t;

    lstate_t                  state_reg;
    logic [SUM_W-1:0]         s_reg;
    logic [KW-1:0]            k_reg;
    logic [MANT_W-1:0]        x_reg;
    logic [2*MANT_W-1:0]      sq_reg;
    logic [LOG_FRAC-1:0]      f_reg;
    logic [BW-1:0]            bcnt_reg;
    logic signed [PW-1:0]     p_reg;
    logic signed [LN_W-1:0]   ln_reg;
    logic                     done_reg;

    logic [31:0]              y;
    logic signed [DW-1:0]     kd;
    logic signed [L2W-1:0]    l2;
    logic signed [PW-1:0]     rnd_sum;

    // log2 fraction: x*x in Q1.30 keeps bits 61..30
    assign y       = sq_reg[61:30];
    assign kd      = $signed({2'b00, k_reg}) - DW'(2 * PROB_FRAC_BITS);
    assign l2      = {kd, f_reg};
    assign rnd_sum = p_reg + RND;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= L_IDLE;
            done_reg  <= 1'b0;
        end else begin
            done_reg <= (state_reg == L_RND);
            unique case (state_reg)
                L_IDLE: begin
                    if (start) begin
                        s_reg     <= sum_in;
                        k_reg     <= KW'(SUM_W - 1);
                        state_reg <= L_NORM;
                    end
                end
                L_NORM: begin
                    // one bit of normalization a cycle, sum is nonzero here
                    if (s_reg[SUM_W-1]) begin
                        x_reg     <= s_reg[SUM_W-1 -: MANT_W];
                        f_reg     <= '0;
                        bcnt_reg  <= '0;
                        state_reg <= L_SQ;
                    end else begin
                        s_reg <= s_reg << 1;
                        k_reg <= k_reg - 1'b1;
                    end
                end
                L_SQ: begin
                    sq_reg    <= (2*MANT_W)'(x_reg) * (2*MANT_W)'(x_reg);
                    state_reg <= L_CHK;
                end
                L_CHK: begin
                    x_reg    <= y[31] ? y[31:1] : y[30:0];
                    f_reg    <= {f_reg[LOG_FRAC-2:0], y[31]};
                    bcnt_reg <= bcnt_reg + 1'b1;
                    if (bcnt_reg == BW'(LOG_FRAC - 1)) begin
                        state_reg <= L_MUL;
                    end else begin
                        state_reg <= L_SQ;
                    end
                end
                L_MUL: begin
                    p_reg     <= l2 * LN2_S;
                    state_reg <= L_RND;
                end
                L_RND: begin
                    ln_reg    <= LN_W'($signed(rnd_sum[PW-1:32]));
                    state_reg <= L_IDLE;
                end
                default: state_reg <= L_IDLE;
            endcase
        end
    end

    assign done = done_reg;
    assign ln   = ln_reg;

endmodule

`default_nettype wire

FILE: rtl/hmm_forward_log_likelihood_top.sv
// Scaled HMM forward pass. Beats with func 0..2 load the initial, transition and
// emission tables (Q1.16, clamped to one). An observation beat runs one step:
// each state in use passes through the single multiply-accumulate pipeline (a
// seed multiply of the initial table on the first symbol), the normalization runs
// each state through the one-bit-a-cycle divider, and the natural log runs in the
// iterative squaring unit. The last symbol of a sequence returns ln P(O) as
// signed Q31.16 and starts a new sequence; a zero step sum flags zero_prob and
// returns the most negative value. A new beat is taken while a finished result
// still waits on the output register.
`default_nettype none

module hmm_forward_log_likelihood_top
    import hfl_pkg::*;
#(
    parameter int MAX_STATES  = 16,
    parameter int NUM_SYMBOLS = 256
) (
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       cfg_we,
    input  wire logic [4:0] cfg_wdata,
    input  wire logic       s_valid,
    output logic            s_ready,
    input  wire in_t        s_data,
    output logic            m_valid,
    input  wire logic       m_ready,
    output out_t            m_data
);

    localparam int SW     = $clog2(MAX_STATES);
    localparam int CW     = $clog2(MAX_STATES + 1);
    localparam int TDEPTH = MAX_STATES * MAX_STATES;
    localparam int TW     = $clog2(TDEPTH);
    localparam int EDEPTH = MAX_STATES * NUM_SYMBOLS;
    localparam int EW     = $clog2(EDEPTH);
    localparam int AN_W   = 2 * PROB_FRAC_BITS + 2;
    localparam int SUM_W  = AN_W + $clog2(MAX_STATES);
    localparam int DC_W   = $clog2(PROB_FRAC_BITS + 1);
    localparam logic [SUM_W:0] HALF = (SUM_W+1)'(1) << (PROB_FRAC_BITS - 1);

    typedef enum logic [3:0] {
        S_IDLE, S_SEED, S_SEED_MUL, S_MAC, S_T, S_A, S_STORE, S_ZERO,
        S_DRD, S_DIV0, S_DIV, S_DWR, S_LOG_GO, S_LOG_WAIT, S_FINISH
    } state_t;

    state_t                  state_reg;
    logic [4:0]              states_reg;
    logic [CW-1:0]           n_reg;
    logic [CW-1:0]           i_reg;
    logic [CW-1:0]           iss_j_reg;
    logic                    rd_v_reg;
    logic                    prod_v_reg;
    logic [2*PROB_W-1:0]     prod_reg;
    logic [SUM_W-1:0]        acc_reg;
    logic [PROB_W-1:0]       t_reg;
    logic [AN_W-1:0]         a_reg;
    logic [SUM_W-1:0]        sum_reg;
    logic [PROB_W-1:0]       q_reg;
    logic [SUM_W-1:0]        r_reg;
    logic [DC_W-1:0]         dcnt_reg;
    logic signed [LOG_W-1:0] log_sum_reg;
    logic                    at_start_reg;
    logic                    zero_seen_reg;
    logic [7:0]              sym_reg;
    logic                    sym_ok_reg;
    logic                    last_reg;
    logic                    m_valid_reg;
    out_t                    m_data_reg;

    logic                    s_acc;
    logic [PROB_W-1:0]       prob_clamped;
    logic                    row_ok;
    logic [CW-1:0]           n_cfg;
    logic [CW-1:0]           n_last;
    logic [SUM_W-1:0]        sum_next;
    logic [SUM_W:0]          t_wide;
    logic [SUM_W:0]          r2;
    logic signed [LOG_W:0]   ls_wide;
    logic signed [LOG_W-1:0] log_sum_next;
    logic                    issue;
    logic                    res_load;

    logic                    init_we, trans_we, emis_we, as_we;
    logic [SW-1:0]           init_waddr;
    logic [TW-1:0]           trans_waddr, trans_raddr;
    logic [EW-1:0]           emis_waddr, emis_raddr;
    logic [PROB_W-1:0]       init_rdata, trans_rdata, emis_rdata, as_rdata, e_eff;
    logic [AN_W-1:0]         an_rdata;

    logic                    log_start, log_done;
    logic signed [LN_W-1:0]  log_ln;

    assign s_ready = (state_reg == S_IDLE);
    assign s_acc   = s_valid && s_ready;

    // table loads go straight to the memories
    assign prob_clamped = (s_data.prob_value > ONE_PROB) ? ONE_PROB : s_data.prob_value;
    assign row_ok       = int'(s_data.row_state) < MAX_STATES;
    assign init_we      = s_acc && (s_data.func == FUNC_INIT) && row_ok;
    assign trans_we     = s_acc && (s_data.func == FUNC_TRANS) && row_ok
                          && (int'(s_data.col_index) < MAX_STATES);
    assign emis_we      = s_acc && (s_data.func == FUNC_EMIS) && row_ok
                          && (int'(s_data.col_index) < NUM_SYMBOLS);
    assign init_waddr   = SW'(s_data.row_state);
    assign trans_waddr  = TW'(TW'(s_data.row_state) * TW'(MAX_STATES)
                          + TW'(s_data.col_index));
    assign emis_waddr   = EW'(EW'(s_data.row_state) * EW'(NUM_SYMBOLS)
                          + EW'(s_data.col_index));

    assign trans_raddr  = TW'(TW'(iss_j_reg) * TW'(MAX_STATES) + TW'(i_reg));
    assign emis_raddr   = EW'(EW'(i_reg) * EW'(NUM_SYMBOLS) + EW'(sym_reg));
    assign e_eff        = sym_ok_reg ? emis_rdata : '0;
    assign as_we        = (state_reg == S_ZERO) || (state_reg == S_DWR);

    always_comb begin
        if (states_reg == '0) begin
            n_cfg = CW'(1);
        end else if (int'(states_reg) > MAX_STATES) begin
            n_cfg = CW'(MAX_STATES);
        end else begin
            n_cfg = CW'(states_reg);
        end
    end

    assign n_last   = n_reg - 1'b1;
    assign issue    = iss_j_reg < n_reg;
    assign sum_next = sum_reg + SUM_W'(a_reg);
    assign t_wide   = ((SUM_W+1)'(acc_reg) + HALF) >> PROB_FRAC_BITS;
    assign r2       = {r_reg, 1'b0};
    assign ls_wide  = {log_sum_reg[LOG_W-1], log_sum_reg}
                      + (LOG_W+1)'(log_ln);
    assign res_load = (state_reg == S_FINISH) && last_reg && (!m_valid_reg || m_ready);

    always_comb begin
        if (ls_wide[LOG_W] != ls_wide[LOG_W-1]) begin
            log_sum_next = ls_wide[LOG_W] ? LOG_MIN : LOG_MAX;
        end else begin
            log_sum_next = ls_wide[LOG_W-1:0];
        end
    end

    assign log_start = (state_reg == S_LOG_GO);

    hfl_ram #(.WIDTH(PROB_W), .DEPTH(MAX_STATES)) u_init (
        .aclk(aclk), .we(init_we), .waddr(init_waddr), .wdata(prob_clamped),
        .raddr(SW'(i_reg)), .rdata(init_rdata)
    );

    hfl_ram #(.WIDTH(PROB_W), .DEPTH(TDEPTH)) u_trans (
        .aclk(aclk), .we(trans_we), .waddr(trans_waddr), .wdata(prob_clamped),
        .raddr(trans_raddr), .rdata(trans_rdata)
    );

    hfl_ram #(.WIDTH(PROB_W), .DEPTH(EDEPTH)) u_emis (
        .aclk(aclk), .we(emis_we), .waddr(emis_waddr), .wdata(prob_clamped),
        .raddr(emis_raddr), .rdata(emis_rdata)
    );

    hfl_ram #(.WIDTH(PROB_W), .DEPTH(MAX_STATES)) u_alpha_scaled (
        .aclk(aclk), .we(as_we), .waddr(SW'(i_reg)),
        .wdata((state_reg == S_DWR) ? q_reg : '0),
        .raddr(SW'(iss_j_reg)), .rdata(as_rdata)
    );

    hfl_ram #(.WIDTH(AN_W), .DEPTH(MAX_STATES)) u_alpha_next (
        .aclk(aclk), .we(state_reg == S_STORE), .waddr(SW'(i_reg)), .wdata(a_reg),
        .raddr(SW'(i_reg)), .rdata(an_rdata)
    );

    hfl_log #(.SUM_W(SUM_W)) u_log (
        .aclk(aclk), .aresetn(aresetn), .start(log_start), .sum_in(sum_reg),
        .done(log_done), .ln(log_ln)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            states_reg    <= 5'd16;
            log_sum_reg   <= '0;
            at_start_reg  <= 1'b1;
            zero_seen_reg <= 1'b0;
            m_valid_reg   <= 1'b0;
            rd_v_reg      <= 1'b0;
            prod_v_reg    <= 1'b0;
        end else begin
            if (cfg_we) begin
                states_reg <= cfg_wdata;
            end
            if (m_valid_reg && m_ready && !res_load) begin
                m_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE: begin
                    if (s_acc && (s_data.func == FUNC_OBS)) begin
                        sym_reg    <= s_data.symbol;
                        sym_ok_reg <= int'(s_data.symbol) < NUM_SYMBOLS;
                        last_reg   <= s_data.last;
                        n_reg      <= n_cfg;
                        i_reg      <= '0;
                        sum_reg    <= '0;
                        iss_j_reg  <= '0;
                        rd_v_reg   <= 1'b0;
                        prod_v_reg <= 1'b0;
                        acc_reg    <= '0;
                        state_reg  <= at_start_reg ? S_SEED : S_MAC;
                    end
                end
                S_SEED: begin
                    // memory read of initial and emission entries in flight
                    state_reg <= S_SEED_MUL;
                end
                S_SEED_MUL: begin
                    a_reg     <= AN_W'(init_rdata) * AN_W'(e_eff);
                    state_reg <= S_STORE;
                end
                S_MAC: begin
                    // read, multiply, accumulate over source states
                    rd_v_reg  <= issue;
                    iss_j_reg <= iss_j_reg + CW'(issue);
                    if (rd_v_reg) begin
                        prod_reg <= (2*PROB_W)'(as_rdata) * (2*PROB_W)'(trans_rdata);
                    end
                    prod_v_reg <= rd_v_reg;
                    if (prod_v_reg) begin
                        acc_reg <= acc_reg + SUM_W'(prod_reg);
                    end
                    if (!issue && !rd_v_reg && !prod_v_reg) begin
                        state_reg <= S_T;
                    end
                end
                S_T: begin
                    t_reg     <= (t_wide > (SUM_W+1)'(T_MAX)) ? T_MAX : PROB_W'(t_wide);
                    state_reg <= S_A;
                end
                S_A: begin
                    a_reg     <= AN_W'(t_reg) * AN_W'(e_eff);
                    state_reg <= S_STORE;
                end
                S_STORE: begin
                    sum_reg <= sum_next;
                    if (i_reg == n_last) begin
                        i_reg     <= '0;
                        state_reg <= (sum_next == '0) ? S_ZERO : S_DRD;
                    end else begin
                        i_reg      <= i_reg + 1'b1;
                        iss_j_reg  <= '0;
                        rd_v_reg   <= 1'b0;
                        prod_v_reg <= 1'b0;
                        acc_reg    <= '0;
                        state_reg  <= at_start_reg ? S_SEED : S_MAC;
                    end
                end
                S_ZERO: begin
                    if (i_reg == n_last) begin
                        zero_seen_reg <= 1'b1;
                        state_reg     <= S_FINISH;
                    end else begin
                        i_reg <= i_reg + 1'b1;
                    end
                end
                S_DRD: begin
                    state_reg <= S_DIV0;
                end
                S_DIV0: begin
                    if (SUM_W'(an_rdata) == sum_reg) begin
                        q_reg <= PROB_W'(1);
                        r_reg <= '0;
                    end else begin
                        q_reg <= '0;
                        r_reg <= SUM_W'(an_rdata);
                    end
                    dcnt_reg  <= '0;
                    state_reg <= S_DIV;
                end
                S_DIV: begin
                    if (r2 >= (SUM_W+1)'(sum_reg)) begin
                        r_reg <= SUM_W'(r2 - (SUM_W+1)'(sum_reg));
                        q_reg <= {q_reg[PROB_W-2:0], 1'b1};
                    end else begin
                        r_reg <= SUM_W'(r2);
                        q_reg <= {q_reg[PROB_W-2:0], 1'b0};
                    end
                    dcnt_reg <= dcnt_reg + 1'b1;
                    if (dcnt_reg == DC_W'(PROB_FRAC_BITS - 1)) begin
                        state_reg <= S_DWR;
                    end
                end
                S_DWR: begin
                    if (i_reg == n_last) begin
                        state_reg <= S_LOG_GO;
                    end else begin
                        i_reg     <= i_reg + 1'b1;
                        state_reg <= S_DRD;
                    end
                end
                S_LOG_GO: begin
                    state_reg <= S_LOG_WAIT;
                end
                S_LOG_WAIT: begin
                    if (log_done) begin
                        log_sum_reg <= log_sum_next;
                        state_reg   <= S_FINISH;
                    end
                end
                S_FINISH: begin
                    if (!last_reg) begin
                        at_start_reg <= 1'b0;
                        state_reg    <= S_IDLE;
                    end else if (res_load) begin
                        m_data_reg.loglik    <= zero_seen_reg ? LOG_MIN : log_sum_reg;
                        m_data_reg.zero_prob <= zero_seen_reg;
                        m_valid_reg          <= 1'b1;
                        log_sum_reg          <= '0;
                        at_start_reg         <= 1'b1;
                        zero_seen_reg        <= 1'b0;
                        state_reg            <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    a_log_done_in_wait: assert property (@(posedge aclk) disable iff (!aresetn)
        log_done |-> state_reg == S_LOG_WAIT)
        else $error("log unit finished outside its wait state");

    a_zero_saturates: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && m_data_reg.zero_prob) |-> m_data_reg.loglik == LOG_MIN)
        else $error("zero_prob result not saturated low");

    a_state_index: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_STORE || state_reg == S_DWR) |-> i_reg < n_reg)
        else $error("state index beyond states in use");

    a_quot_range: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == S_DWR |-> q_reg <= ONE_PROB)
        else $error("scaled alpha above one");

    a_mac_pipe: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_MAC && rd_v_reg) |=> (prod_v_reg && state_reg == S_MAC))
        else $error("mac pipeline dropped a product");

endmodule

`default_nettype wire

FILE: bench/hmm_forward_log_likelihood_top_tb.sv
`default_nettype none

class hmm_forward_scoreboard;
    longint unsigned init_p[16];
    longint unsigned trans_p[256];
    longint unsigned emis_p[4096];
    longint unsigned alpha_s[16];
    longint unsigned alpha_n[16];
    longint          log_acc;
    bit              fresh;
    bit              zero_hit;
    int unsigned     n_states;
    hfl_pkg::out_t   pending[$];
    int              fails;

    function new();
        log_acc  = 0;
        fresh    = 1;
        zero_hit = 0;
        n_states = 16;
        fails    = 0;
    endfunction

    function void set_states(logic [4:0] v);
        n_states = v;
    endfunction

    // floor(a * 2^16 / s), clamped to one
    function longint unsigned frac_div(longint unsigned a, longint unsigned s);
        longint unsigned q, r;
        if (a > s) begin
            return longint'(hfl_pkg::ONE_PROB);
        end
        q = (a == s) ? 1 : 0;
        r = (a == s) ? 0 : a;
        for (int k = 0; k < hfl_pkg::PROB_FRAC_BITS; k++) begin
            q = q << 1;
            if (r >= s - r) begin
                r = r - (s - r);
                q = q | 1;
            end else begin
                r = r << 1;
            end
        end
        return q;
    endfunction

    // ln of s / 2^32 in Q.16
    function longint ln_step(longint unsigned s);
        int              k;
        longint unsigned x, f, u;
        longint          l2, p;
        k = 63;
        f = 0;
        while (((s >> k) & 1) == 0) k--;
        x = (k >= 30) ? (s >> (k - 30)) : (s << (30 - k));
        for (int b = 0; b < hfl_pkg::LOG_FRAC; b++) begin
            x = (x * x) >> 30;
            f = f << 1;
            if (x >= (64'd1 << 31)) begin
                x = x >> 1;
                f = f | 1;
            end
        end
        l2 = (longint'(k) - 2 * hfl_pkg::PROB_FRAC_BITS) * 65536 + longint'(f);
        p  = l2 * longint'({32'd0, hfl_pkg::LN2_Q32});
        u  = p + (64'sd1 <<< 31) + (64'sd1 <<< 62);
        return longint'(u >> 32) - (64'sd1 <<< 30);
    endfunction

    function void note_input(hfl_pkg::in_t it);
        longint unsigned prob, e, a, s, t, total;
        longint          v;
        int unsigned     n;
        hfl_pkg::out_t   res;
        prob = (it.prob_value > hfl_pkg::ONE_PROB) ? hfl_pkg::ONE_PROB : it.prob_value;
        case (it.func)
            hfl_pkg::FUNC_INIT: begin
                init_p[it.row_state] = prob;
            end
            hfl_pkg::FUNC_TRANS: begin
                if (it.col_index < 16) trans_p[it.row_state * 16 + it.col_index] = prob;
            end
            hfl_pkg::FUNC_EMIS: begin
                emis_p[it.row_state * 256 + it.col_index] = prob;
            end
            default: begin
                n = (n_states == 0) ? 1 : (n_states > 16 ? 16 : n_states);
                total = 0;
                for (int i = 0; i < n; i++) begin
                    e = emis_p[i * 256 + it.symbol];
                    if (fresh) begin
                        a = init_p[i] * e;
                    end else begin
                        s = 0;
                        for (int j = 0; j < n; j++) s += alpha_s[j] * trans_p[j * 16 + i];
                        t = (s + (64'd1 << (hfl_pkg::PROB_FRAC_BITS - 1)))
                            >> hfl_pkg::PROB_FRAC_BITS;
                        if (t > longint'(hfl_pkg::T_MAX)) t = hfl_pkg::T_MAX;
                        a = t * e;
                    end
                    alpha_n[i] = a;
                    total += a;
                end
                if (total == 0) begin
                    zero_hit = 1;
                    for (int i = 0; i < n; i++) alpha_s[i] = 0;
                end else begin
                    for (int i = 0; i < n; i++) alpha_s[i] = frac_div(alpha_n[i], total);
                    v = log_acc + ln_step(total);
                    if (v < -(64'sd1 <<< 47)) v = -(64'sd1 <<< 47);
                    if (v > (64'sd1 <<< 47) - 1) v = (64'sd1 <<< 47) - 1;
                    log_acc = v;
                end
                fresh = 0;
                if (it.last) begin
                    res.loglik    = zero_hit ? hfl_pkg::LOG_MIN : log_acc[47:0];
                    res.zero_prob = zero_hit;
                    pending.push_back(res);
                    log_acc  = 0;
                    fresh    = 1;
                    zero_hit = 0;
                end
            end
        endcase
    endfunction

    function void check_result(hfl_pkg::out_t got);
        hfl_pkg::out_t want;
        if (pending.size() == 0) begin
            $error("result beat with nothing expected: loglik %0d", got.loglik);
            fails++;
            return;
        end
        want = pending.pop_front();
        if (got.loglik !== want.loglik) begin
            $error("loglik expected %0d actual %0d", want.loglik, got.loglik);
            fails++;
        end
        if (got.zero_prob !== want.zero_prob) begin
            $error("zero_prob expected %0b actual %0b", want.zero_prob, got.zero_prob);
            fails++;
        end
    endfunction
endclass

module hmm_forward_log_likelihood_top_tb
    import hfl_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT = 3000000;
    localparam int DRAIN_WAIT  = 800;

    logic        aclk;
    logic        aresetn;
    logic        cfg_we;
    logic [4:0]  cfg_wdata;
    logic        s_valid;
    logic        s_ready;
    in_t         s_data;
    logic        m_valid;
    logic        m_ready;
    out_t        m_data;

    hmm_forward_scoreboard sb;
    int          cycles;
    int          rx_hold;
    int          rx_wait;
    bit          rx_fast;
    bit          tx_fast;
    int          beats_sent;
    bit          emis_ok[16][256];
    int          sym_pool[$];

    hmm_forward_log_likelihood_top dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

    initial begin
        aclk = 0;
        forever #5 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    // result side: per-beat stall, plus a long hold counted here
    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_valid && m_ready) begin
                sb.check_result(m_data);
                rx_wait = rx_fast ? 0 : $urandom_range(0, 16);
            end
            if (rx_hold > 0) begin
                rx_hold--;
                m_ready <= 1'b0;
            end else if (rx_wait > 0) begin
                rx_wait--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    function automatic logic [16:0] rand_prob();
        case ($urandom_range(0, 15))
            0:       return 17'd0;
            1:       return ONE_PROB;
            2:       return 17'($urandom_range(65537, 131071));
            default: return 17'($urandom_range(1, 65536));
        endcase
    endfunction

    // leaves s_valid high; anything that spends time afterwards lowers it first
    task automatic send(in_t it);
        int gap;
        gap = tx_fast ? 0 : $urandom_range(0, 16);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= it;
        do @(posedge aclk); while (!s_ready);
        sb.note_input(it);
        beats_sent++;
    endtask

    task automatic write_table(func_t f, logic [3:0] row, logic [7:0] col, logic [16:0] p);
        in_t it;
        bit  full;
        it.func       = f;
        it.row_state  = row;
        it.col_index  = col;
        it.prob_value = p;
        it.symbol     = 8'($urandom_range(0, 255));
        it.last       = 1'($urandom_range(0, 1));
        send(it);
        if (f == FUNC_EMIS) begin
            emis_ok[row][col] = 1;
            full = 1;
            for (int i = 0; i < 16; i++) full &= emis_ok[i][col];
            if (full && !(col inside {sym_pool})) sym_pool.push_back(col);
        end
    endtask

    task automatic observe(logic [7:0] sym, logic fin);
        in_t it;
        it.func       = FUNC_OBS;
        it.row_state  = 4'($urandom_range(0, 15));
        it.col_index  = 8'($urandom_range(0, 255));
        it.prob_value = 17'($urandom_range(0, 131071));
        it.symbol     = sym;
        it.last       = fin;
        send(it);
    endtask

    task automatic drain();
        s_valid <= 1'b0;
        while (sb.pending.size() > 0) @(posedge aclk);
        repeat (DRAIN_WAIT) @(posedge aclk);
    endtask

    task automatic write_states(logic [4:0] v);
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        @(posedge aclk);
        cfg_we    <= 1'b0;
        sb.set_states(v);
    endtask

    task automatic random_write();
        logic [7:0] col;
        case ($urandom_range(0, 2))
            0: write_table(FUNC_INIT, 4'($urandom_range(0, 15)), 8'($urandom_range(0, 255)),
                           rand_prob());
            1: begin
                col = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 255))
                                                  : 8'($urandom_range(0, 15));
                write_table(FUNC_TRANS, 4'($urandom_range(0, 15)), col, rand_prob());
            end
            default: begin
                col = ($urandom_range(0, 3) == 0)
                      ? 8'($urandom_range(0, 255))
                      : 8'(sym_pool[$urandom_range(0, sym_pool.size() - 1)]);
                write_table(FUNC_EMIS, 4'($urandom_range(0, 15)), col, rand_prob());
            end
        endcase
    endtask

    initial begin
        int      len;
        logic [4:0] phase_states[8] = '{5'd1, 5'd0, 5'd31, 5'd2, 5'd5, 5'd16, 5'd7, 5'd16};
        sb         = new();
        cycles     = 0;
        rx_hold    = 0;
        rx_wait    = 0;
        rx_fast    = 0;
        tx_fast    = 0;
        beats_sent = 0;
        aresetn    = 1'b0;
        cfg_we     = 1'b0;
        cfg_wdata  = '0;
        s_valid    = 1'b0;
        s_data     = '0;
        m_ready    = 1'b0;
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        write_states(5'd16);

        // full tables, with clamped and zero values at the edges
        for (int i = 0; i < 16; i++)
            write_table(FUNC_INIT, 4'(i), 8'd0,
                        i == 0 ? 17'h1FFFF : (i == 1 ? 17'd0 : rand_prob()));
        for (int i = 0; i < 256; i++)
            write_table(FUNC_TRANS, 4'(i / 16), 8'(i % 16),
                        i == 255 ? ONE_PROB : rand_prob());
        write_table(FUNC_TRANS, 4'd15, 8'd200, 17'd12345);
        foreach (emis_ok[i, j]) emis_ok[i][j] = 0;
        for (int i = 0; i < 16; i++) begin
            write_table(FUNC_EMIS, 4'(i), 8'h00, rand_prob());
            write_table(FUNC_EMIS, 4'(i), 8'hFF, i == 15 ? 17'h1FFFF : rand_prob());
            write_table(FUNC_EMIS, 4'(i), 8'hAA, 17'($urandom_range(1, 65536)));
            // a symbol no state can emit gives a zero step sum
            write_table(FUNC_EMIS, 4'(i), 8'h55, 17'd0);
        end

        observe(8'h00, 1'b1);
        observe(8'h00, 1'b0);
        observe(8'hFF, 1'b0);
        observe(8'hAA, 1'b1);
        observe(8'hAA, 1'b0);
        observe(8'h55, 1'b0);
        observe(8'hFF, 1'b1);
        observe(8'h55, 1'b1);
        observe(8'hFF, 1'b1);
        drain();

        for (int ph = 0; ph < 8; ph++) begin
            int start;
            write_states(phase_states[ph]);
            tx_fast = (ph % 3 == 1);
            rx_fast = (ph % 4 == 2);
            if (ph == 3) rx_hold = 6000;
            start = beats_sent;
            while (beats_sent - start < 63) begin
                len = ($urandom_range(0, 4) == 0) ? 1 : $urandom_range(2, 6);
                for (int k = 0; k < len; k++) begin
                    if ($urandom_range(0, 3) == 0) random_write();
                    observe(8'(sym_pool[$urandom_range(0, sym_pool.size() - 1)]),
                            k == len - 1);
                end
            end
            drain();
        end

        if (sb.fails == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end
endmodule

`default_nettype wire
